// File: src/homogeneous_line_clip_project_core_defines.svh
// Assertion macros shared by the homogeneous line clipper RTL.
// Each macro samples on the clock and is disabled during reset.
`ifndef HOMOGENEOUS_LINE_CLIP_PROJECT_CORE_DEFINES_SVH
`define HOMOGENEOUS_LINE_CLIP_PROJECT_CORE_DEFINES_SVH

// Same-cycle implication.
`define HLCP_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define HLCP_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/hlcp_pkg.sv
// Package for the homogeneous line clipper: widths, constants, payload types.
// Used by every module of the block; depends on nothing.
package hlcp_pkg;

   localparam int COORD_FRAC_BITS = 16;
   localparam int COORD_W         = 32;
   localparam int NUM_BOUNDS      = 6;
   localparam int BOUND_W         = COORD_W + 1;
   localparam int DEN_W           = BOUND_W + 1;
   localparam int ALPHA_W         = COORD_FRAC_BITS + 1;
   localparam int ADIV_W          = DEN_W + ALPHA_W;
   localparam int DIFF_W          = COORD_W + 1;
   localparam int PROD_W          = DIFF_W + ALPHA_W + 1;
   localparam int NUM_W           = COORD_W + 2;
   localparam int NDC_Q_W         = COORD_W;
   localparam int NDIV_W          = COORD_W + NDC_Q_W;
   localparam int SCR_PROD_W      = 2 * COORD_W;
   localparam int SCR_SUM_W       = SCR_PROD_W - COORD_FRAC_BITS + 1;
   localparam int LANE_STAGES     = 6 + NDC_Q_W + 3;
   localparam int CSR_ADDR_W      = 4;
   localparam int CSR_DATA_W      = 32;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << COORD_FRAC_BITS;
   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef enum logic [1:0] {
      REG_SCALE_X  = 2'd0,
      REG_OFFSET_X = 2'd1,
      REG_SCALE_Y  = 2'd2,
      REG_OFFSET_Y = 2'd3
   } csr_index_type;

   typedef struct packed {
      coord_type start_x;
      coord_type start_y;
      coord_type start_z;
      coord_type start_w;
      coord_type end_x;
      coord_type end_y;
      coord_type end_z;
      coord_type end_w;
   } seg_in_type;

   typedef struct packed {
      coord_type screen_start_x;
      coord_type screen_start_y;
      coord_type screen_end_x;
      coord_type screen_end_y;
      logic      was_clipped;
   } seg_out_type;

   typedef struct packed {
      logic               valid;
      logic               clipped;
      logic [ALPHA_W-1:0] alpha0;
      logic [ALPHA_W-1:0] alpha1;
      seg_in_type         seg;
   } front_out_type;

endpackage

// File: src/homogeneous_line_clip_project_core.sv
// Homogeneous line clipper top level: CSR block, pipeline stall control and
// result register. Uses hlcp_pkg, hlcp_clip_front, hlcp_project and the defines.
//
// Usage: a segment (two homogeneous points) is offered on the req_ channel
// and taken when req_valid and req_ready are both high. A surviving segment
// comes back as one transaction on the rsp_ channel; a segment rejected by
// the outcode test or by crossed alphas produces no transaction.
// The alpha dividers take COORD_FRAC_BITS + 1 stages and the NDC dividers 32
// stages, one quotient bit per stage. One segment is accepted every cycle
// while the pipeline is not stalled.
// When the receiver stalls, the result register holds its transaction; the
// pipeline keeps moving until a finished result reaches its last stage, and
// only then stops taking new segments. Bubbles and rejected segments drain
// without stalling.
// Reset clears all valid bits and the four viewport registers to zero.
// Viewport registers sit on the csr_ port at byte addresses 0, 4, 8 and 12
// and should be written only while no segment is in flight.
`include "homogeneous_line_clip_project_core_defines.svh"

module homogeneous_line_clip_project_core
   import hlcp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  seg_in_type            req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output seg_out_type           rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   coord_type     scale_x_ff, offset_x_ff, scale_y_ff, offset_y_ff;
   csr_index_type csr_index;
   logic          csr_wr;
   logic          adv;
   front_out_type front_out;
   logic          pipe_valid;
   seg_out_type   pipe_data;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   seg_out_type   rsp_data_ff;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_x_ff  <= '0;
         offset_x_ff <= '0;
         scale_y_ff  <= '0;
         offset_y_ff <= '0;
      end else if (csr_wr) begin
         case (csr_index)
            REG_SCALE_X:  scale_x_ff  <= csr_pwdata;
            REG_OFFSET_X: offset_x_ff <= csr_pwdata;
            REG_SCALE_Y:  scale_y_ff  <= csr_pwdata;
            REG_OFFSET_Y: offset_y_ff <= csr_pwdata;
            default:      scale_x_ff  <= scale_x_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_SCALE_X:  csr_prdata = scale_x_ff;
         REG_OFFSET_X: csr_prdata = offset_x_ff;
         REG_SCALE_Y:  csr_prdata = scale_y_ff;
         REG_OFFSET_Y: csr_prdata = offset_y_ff;
         default:      csr_prdata = '0;
      endcase
   end

   // The pipeline stops only when a finished result cannot enter the
   // result register.
   assign adv       = !(pipe_valid && rsp_valid_ff && !rsp_ready);
   assign req_ready = adv;

   hlcp_clip_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .front_out (front_out)
   );

   hlcp_project u_project (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .front_in   (front_out),
      .scale_x    (scale_x_ff),
      .offset_x   (offset_x_ff),
      .scale_y    (scale_y_ff),
      .offset_y   (offset_y_ff),
      .last_valid (pipe_valid),
      .last_data  (pipe_data)
   );

   always_comb begin
      if (pipe_valid && adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_valid && adv) begin
         rsp_data_ff <= pipe_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `HLCP_ASSERT_IMP(a_stall_needs_full_output, pipe_valid && !req_ready,
                    rsp_valid && !rsp_ready, "pipeline stalled with the output free")
   `HLCP_ASSERT_NXT(a_result_reaches_output, pipe_valid && req_ready,
                    rsp_valid, "finished transaction did not reach the output")
   `HLCP_ASSERT_IMP(a_output_rise_has_source, $rose(rsp_valid),
                    $past(pipe_valid), "output transaction appeared from nowhere")
   `HLCP_ASSERT_NXT(a_scale_x_write, csr_wr && (csr_index == REG_SCALE_X),
                    scale_x_ff == $past(csr_pwdata), "scale x write was lost")

endmodule

// File: src/hlcp_clip_front.sv
// Clip front end: boundary values, outcodes, trivial reject, pipelined alpha
// dividers (one quotient bit per stage) and entry/exit selection. Uses hlcp_pkg.
module hlcp_clip_front
   import hlcp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  logic          in_valid,
   input  seg_in_type    in_data,
   output front_out_type front_out
);

   logic signed [BOUND_W-1:0] bc0_in [NUM_BOUNDS];
   logic signed [BOUND_W-1:0] bc1_in [NUM_BOUNDS];
   logic signed [BOUND_W-1:0] bc0_ff [NUM_BOUNDS];
   logic signed [BOUND_W-1:0] bc1_ff [NUM_BOUNDS];
   logic                      f1_valid_ff;
   seg_in_type                f1_seg_ff;

   logic [ADIV_W-1:0]     rem_in   [ALPHA_W+1][NUM_BOUNDS];
   logic [ADIV_W-1:0]     rem_ff   [ALPHA_W+1][NUM_BOUNDS];
   logic [DEN_W-1:0]      den_in   [ALPHA_W+1][NUM_BOUNDS];
   logic [DEN_W-1:0]      den_ff   [ALPHA_W+1][NUM_BOUNDS];
   logic [ALPHA_W-1:0]    q_in     [ALPHA_W+1][NUM_BOUNDS];
   logic [ALPHA_W-1:0]    q_ff     [ALPHA_W+1][NUM_BOUNDS];
   logic [NUM_BOUNDS-1:0] code0_in [ALPHA_W+1];
   logic [NUM_BOUNDS-1:0] code0_ff [ALPHA_W+1];
   logic [NUM_BOUNDS-1:0] code1_in [ALPHA_W+1];
   logic [NUM_BOUNDS-1:0] code1_ff [ALPHA_W+1];
   seg_in_type            dseg_in  [ALPHA_W+1];
   seg_in_type            dseg_ff  [ALPHA_W+1];
   logic [ALPHA_W:0]      dvalid_in;
   logic [ALPHA_W:0]      dvalid_ff;

   logic               av_ff;
   logic               aclip_in;
   logic               aclip_ff;
   logic [ALPHA_W-1:0] a0_in;
   logic [ALPHA_W-1:0] a0_ff;
   logic [ALPHA_W-1:0] a1_in;
   logic [ALPHA_W-1:0] a1_ff;
   seg_in_type         aseg_ff;

   always_comb begin
      bc0_in[0] = BOUND_W'(in_data.start_x);
      bc0_in[1] = BOUND_W'(in_data.start_w) - BOUND_W'(in_data.start_x);
      bc0_in[2] = BOUND_W'(in_data.start_y);
      bc0_in[3] = BOUND_W'(in_data.start_w) - BOUND_W'(in_data.start_y);
      bc0_in[4] = BOUND_W'(in_data.start_z);
      bc0_in[5] = BOUND_W'(in_data.start_w) - BOUND_W'(in_data.start_z);
      bc1_in[0] = BOUND_W'(in_data.end_x);
      bc1_in[1] = BOUND_W'(in_data.end_w) - BOUND_W'(in_data.end_x);
      bc1_in[2] = BOUND_W'(in_data.end_y);
      bc1_in[3] = BOUND_W'(in_data.end_w) - BOUND_W'(in_data.end_y);
      bc1_in[4] = BOUND_W'(in_data.end_z);
      bc1_in[5] = BOUND_W'(in_data.end_w) - BOUND_W'(in_data.end_z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else if (adv) begin
         f1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_seg_ff <= in_data;
         for (int i = 0; i < NUM_BOUNDS; i++) begin
            bc0_ff[i] <= bc0_in[i];
            bc1_ff[i] <= bc1_in[i];
         end
      end
   end

   // Stage 0 sets up |bc0| * 2^F / |bc0 - bc1| for every crossed boundary.
   // Both operands share a sign there, so the quotient is 0 .. 2^F.
   always_comb begin
      logic [NUM_BOUNDS-1:0]     c0;
      logic [NUM_BOUNDS-1:0]     c1;
      logic signed [DEN_W-1:0]   diff;
      logic [BOUND_W-1:0]        abs0;
      logic [ADIV_W-1:0]         trial;
      for (int i = 0; i < NUM_BOUNDS; i++) begin
         c0[i] = bc0_ff[i][BOUND_W-1];
         c1[i] = bc1_ff[i][BOUND_W-1];
      end
      dvalid_in[0] = f1_valid_ff && ((c0 & c1) == '0);
      code0_in[0]  = c0;
      code1_in[0]  = c1;
      dseg_in[0]   = f1_seg_ff;
      for (int i = 0; i < NUM_BOUNDS; i++) begin
         diff = DEN_W'(bc0_ff[i]) - DEN_W'(bc1_ff[i]);
         abs0 = c0[i] ? -bc0_ff[i] : bc0_ff[i];
         if (c0[i] || c1[i]) begin
            rem_in[0][i] = ADIV_W'(abs0) << COORD_FRAC_BITS;
            den_in[0][i] = diff[DEN_W-1] ? -diff : diff;
         end else begin
            rem_in[0][i] = '0;
            den_in[0][i] = DEN_W'(1);
         end
         q_in[0][i] = '0;
      end
      for (int s = 1; s <= ALPHA_W; s++) begin
         dvalid_in[s] = dvalid_ff[s-1];
         code0_in[s]  = code0_ff[s-1];
         code1_in[s]  = code1_ff[s-1];
         dseg_in[s]   = dseg_ff[s-1];
         for (int i = 0; i < NUM_BOUNDS; i++) begin
            trial        = ADIV_W'(den_ff[s-1][i]) << (ALPHA_W - s);
            den_in[s][i] = den_ff[s-1][i];
            if (rem_ff[s-1][i] >= trial) begin
               rem_in[s][i] = rem_ff[s-1][i] - trial;
               q_in[s][i]   = q_ff[s-1][i] | (ALPHA_W'(1) << (ALPHA_W - s));
            end else begin
               rem_in[s][i] = rem_ff[s-1][i];
               q_in[s][i]   = q_ff[s-1][i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dvalid_ff <= '0;
      end else if (adv) begin
         dvalid_ff <= dvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = 0; s <= ALPHA_W; s++) begin
            code0_ff[s] <= code0_in[s];
            code1_ff[s] <= code1_in[s];
            dseg_ff[s]  <= dseg_in[s];
            for (int i = 0; i < NUM_BOUNDS; i++) begin
               rem_ff[s][i] <= rem_in[s][i];
               den_ff[s][i] <= den_in[s][i];
               q_ff[s][i]   <= q_in[s][i];
            end
         end
      end
   end

   // Entering boundaries raise alpha0, leaving boundaries lower alpha1.
   always_comb begin
      a0_in = '0;
      a1_in = ALPHA_ONE;
      for (int i = 0; i < NUM_BOUNDS; i++) begin
         if (code0_ff[ALPHA_W][i]) begin
            if (q_ff[ALPHA_W][i] > a0_in) begin
               a0_in = q_ff[ALPHA_W][i];
            end
         end else if (code1_ff[ALPHA_W][i]) begin
            if (q_ff[ALPHA_W][i] < a1_in) begin
               a1_in = q_ff[ALPHA_W][i];
            end
         end
      end
      aclip_in = (code0_ff[ALPHA_W] | code1_ff[ALPHA_W]) != '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         av_ff <= 1'b0;
      end else if (adv) begin
         av_ff <= dvalid_ff[ALPHA_W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         aclip_ff <= aclip_in;
         a0_ff    <= a0_in;
         a1_ff    <= a1_in;
         aseg_ff  <= dseg_ff[ALPHA_W];
      end
   end

   assign front_out = '{valid: av_ff, clipped: aclip_ff, alpha0: a0_ff,
                        alpha1: a1_ff, seg: aseg_ff};

endmodule

// File: src/hlcp_proj_lane.sv
// One screen coordinate lane: interpolation, 2v-w, pipelined NDC divider
// (one quotient bit per stage), viewport scale and offset. Uses hlcp_pkg.
module hlcp_proj_lane
   import hlcp_pkg::*;
(
   input  logic               clock,
   input  logic               adv,
   input  coord_type          base_v,
   input  coord_type          tgt_v,
   input  coord_type          base_w,
   input  coord_type          tgt_w,
   input  logic [ALPHA_W-1:0] alpha,
   input  coord_type          scale,
   input  coord_type          offset,
   output coord_type          screen
);

   typedef struct packed {
      logic ovf;
      logic neg;
      logic wzero;
      logic npos;
      logic nneg;
   } ndc_flag_type;

   logic signed [DIFF_W-1:0] dv_ff, dw_ff;
   coord_type                b1v_ff, b1w_ff;
   logic [ALPHA_W-1:0]       alpha_ff;
   logic signed [PROD_W-1:0] pv_in, pw_in, pv_ff, pw_ff;
   coord_type                b2v_ff, b2w_ff;
   coord_type                qv_ff, qw_ff;
   logic signed [NUM_W-1:0]  num_ff;
   coord_type                w4_ff;
   logic [NUM_W-1:0]         magn_in, magn_ff;
   logic [COORD_W-1:0]       magw5_in, magw5_ff;
   ndc_flag_type             flg5_in, flg5_ff;

   logic [NDIV_W-1:0]  rem_in  [NDC_Q_W+1];
   logic [NDIV_W-1:0]  rem_ff  [NDC_Q_W+1];
   logic [COORD_W-1:0] magw_in [NDC_Q_W+1];
   logic [COORD_W-1:0] magw_ff [NDC_Q_W+1];
   logic [NDC_Q_W-1:0] q_in    [NDC_Q_W+1];
   logic [NDC_Q_W-1:0] q_ff    [NDC_Q_W+1];
   ndc_flag_type       flg_in  [NDC_Q_W+1];
   ndc_flag_type       flg_ff  [NDC_Q_W+1];

   coord_type                    ndc_in, ndc_ff;
   logic signed [SCR_PROD_W-1:0] sp_ff;
   logic signed [SCR_SUM_W-1:0]  sum;
   coord_type                    scr_in, scr_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_ff    <= DIFF_W'(tgt_v) - DIFF_W'(base_v);
         dw_ff    <= DIFF_W'(tgt_w) - DIFF_W'(base_w);
         b1v_ff   <= base_v;
         b1w_ff   <= base_w;
         alpha_ff <= alpha;
      end
   end

   assign pv_in = $signed({1'b0, alpha_ff}) * dv_ff;
   assign pw_in = $signed({1'b0, alpha_ff}) * dw_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         pv_ff  <= pv_in;
         pw_ff  <= pw_in;
         b2v_ff <= b1v_ff;
         b2w_ff <= b1w_ff;
      end
   end

   // The interpolated point lies between the endpoints, so 32 bits hold it.
   always_ff @(posedge clock) begin
      if (adv) begin
         qv_ff  <= b2v_ff + COORD_W'(pv_ff >>> COORD_FRAC_BITS);
         qw_ff  <= b2w_ff + COORD_W'(pw_ff >>> COORD_FRAC_BITS);
         num_ff <= (NUM_W'(qv_ff) <<< 1) - NUM_W'(qw_ff);
         w4_ff  <= qw_ff;
      end
   end

   always_comb begin
      magn_in       = num_ff[NUM_W-1] ? -num_ff : num_ff;
      magw5_in      = w4_ff[COORD_W-1] ? -w4_ff : w4_ff;
      flg5_in.ovf   = 1'b0;
      flg5_in.neg   = num_ff[NUM_W-1] ^ w4_ff[COORD_W-1];
      flg5_in.wzero = (w4_ff == '0);
      flg5_in.npos  = !num_ff[NUM_W-1] && (num_ff != '0);
      flg5_in.nneg  = num_ff[NUM_W-1];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         magn_ff  <= magn_in;
         magw5_ff <= magw5_in;
         flg5_ff  <= flg5_in;
      end
   end

   // Stage 0 flags a quotient of 2^32 or more, then the divider runs MSB first.
   always_comb begin
      logic [NDIV_W-1:0] trial;
      flg_in[0]     = flg5_ff;
      flg_in[0].ovf = (magn_ff >> (NDC_Q_W - COORD_FRAC_BITS)) >= NUM_W'(magw5_ff);
      rem_in[0]     = NDIV_W'(magn_ff) << COORD_FRAC_BITS;
      magw_in[0]    = magw5_ff;
      q_in[0]       = '0;
      for (int s = 1; s <= NDC_Q_W; s++) begin
         trial      = NDIV_W'(magw_ff[s-1]) << (NDC_Q_W - s);
         flg_in[s]  = flg_ff[s-1];
         magw_in[s] = magw_ff[s-1];
         if (rem_ff[s-1] >= trial) begin
            rem_in[s] = rem_ff[s-1] - trial;
            q_in[s]   = q_ff[s-1] | (NDC_Q_W'(1) << (NDC_Q_W - s));
         end else begin
            rem_in[s] = rem_ff[s-1];
            q_in[s]   = q_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = 0; s <= NDC_Q_W; s++) begin
            rem_ff[s]  <= rem_in[s];
            magw_ff[s] <= magw_in[s];
            q_ff[s]    <= q_in[s];
            flg_ff[s]  <= flg_in[s];
         end
      end
   end

   always_comb begin
      if (flg_ff[NDC_Q_W].wzero) begin
         if (flg_ff[NDC_Q_W].npos) begin
            ndc_in = COORD_MAX;
         end else if (flg_ff[NDC_Q_W].nneg) begin
            ndc_in = COORD_MIN;
         end else begin
            ndc_in = '0;
         end
      end else if (flg_ff[NDC_Q_W].ovf || q_ff[NDC_Q_W][NDC_Q_W-1]) begin
         ndc_in = flg_ff[NDC_Q_W].neg ? COORD_MIN : COORD_MAX;
      end else begin
         ndc_in = flg_ff[NDC_Q_W].neg ? -coord_type'(q_ff[NDC_Q_W])
                                      : coord_type'(q_ff[NDC_Q_W]);
      end
   end

   always_comb begin
      sum = SCR_SUM_W'(sp_ff >>> COORD_FRAC_BITS) + SCR_SUM_W'(offset);
      if (sum > SCR_SUM_W'(COORD_MAX)) begin
         scr_in = COORD_MAX;
      end else if (sum < SCR_SUM_W'(COORD_MIN)) begin
         scr_in = COORD_MIN;
      end else begin
         scr_in = COORD_W'(sum);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ndc_ff <= ndc_in;
         sp_ff  <= scale * ndc_ff;
         scr_ff <= scr_in;
      end
   end

   assign screen = scr_ff;

endmodule

// File: src/hlcp_project.sv
// Projection back end: late reject on crossed alphas, four coordinate lanes
// and the valid line that travels beside them. Uses hlcp_pkg, hlcp_proj_lane.
module hlcp_project
   import hlcp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  front_out_type front_in,
   input  coord_type     scale_x,
   input  coord_type     offset_x,
   input  coord_type     scale_y,
   input  coord_type     offset_y,
   output logic          last_valid,
   output seg_out_type   last_data
);

   logic                   keep;
   logic [LANE_STAGES-1:0] vl_ff;
   logic [LANE_STAGES-1:0] cl_ff;

   // The exit falling before the entry rejects the segment.
   assign keep = front_in.valid && !(front_in.alpha1 < front_in.alpha0);

   always_ff @(posedge clock) begin
      if (reset) begin
         vl_ff <= '0;
      end else if (adv) begin
         vl_ff <= {vl_ff[LANE_STAGES-2:0], keep};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cl_ff <= {cl_ff[LANE_STAGES-2:0], front_in.clipped};
      end
   end

   hlcp_proj_lane u_start_x (
      .clock  (clock),
      .adv    (adv),
      .base_v (front_in.seg.start_x),
      .tgt_v  (front_in.seg.end_x),
      .base_w (front_in.seg.start_w),
      .tgt_w  (front_in.seg.end_w),
      .alpha  (front_in.alpha0),
      .scale  (scale_x),
      .offset (offset_x),
      .screen (last_data.screen_start_x)
   );

   hlcp_proj_lane u_start_y (
      .clock  (clock),
      .adv    (adv),
      .base_v (front_in.seg.start_y),
      .tgt_v  (front_in.seg.end_y),
      .base_w (front_in.seg.start_w),
      .tgt_w  (front_in.seg.end_w),
      .alpha  (front_in.alpha0),
      .scale  (scale_y),
      .offset (offset_y),
      .screen (last_data.screen_start_y)
   );

   hlcp_proj_lane u_end_x (
      .clock  (clock),
      .adv    (adv),
      .base_v (front_in.seg.start_x),
      .tgt_v  (front_in.seg.end_x),
      .base_w (front_in.seg.start_w),
      .tgt_w  (front_in.seg.end_w),
      .alpha  (front_in.alpha1),
      .scale  (scale_x),
      .offset (offset_x),
      .screen (last_data.screen_end_x)
   );

   hlcp_proj_lane u_end_y (
      .clock  (clock),
      .adv    (adv),
      .base_v (front_in.seg.start_y),
      .tgt_v  (front_in.seg.end_y),
      .base_w (front_in.seg.start_w),
      .tgt_w  (front_in.seg.end_w),
      .alpha  (front_in.alpha1),
      .scale  (scale_y),
      .offset (offset_y),
      .screen (last_data.screen_end_y)
   );

   assign last_data.was_clipped = cl_ff[LANE_STAGES-1];
   assign last_valid            = vl_ff[LANE_STAGES-1];

endmodule

// File: tb/hlcp_checker.sv
// Scoreboard for the homogeneous line clipper: predicts each accepted segment,
// tracks viewport writes on the csr_ port and compares every rsp_ transaction.
// Depends on hlcp_pkg only.
module hlcp_checker
   import hlcp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  seg_in_type            req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  seg_out_type           rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int                    fail_count,
   output int                    pending,
   output int                    seg_count,
   output int                    drawn_count,
   output int                    clipped_count
);

   localparam longint FRAC_ONE = longint'(1) <<< COORD_FRAC_BITS;
   localparam longint S32_HI   = 64'sd2147483647;
   localparam longint S32_LO   = -64'sd2147483648;

   seg_out_type screen_q[$];
   longint      vp_scale_x, vp_offset_x, vp_scale_y, vp_offset_y;
   int          fails, n_seg, n_drawn, n_clipped;

   function automatic longint sat32(longint v);
      if (v > S32_HI) return S32_HI;
      if (v < S32_LO) return S32_LO;
      return v;
   endfunction

   // Division rounding toward minus infinity by one unit of the fixed format.
   function automatic longint floor_unit(longint v);
      longint q;
      q = v / FRAC_ONE;
      if ((v % FRAC_ONE) != 0 && v < 0) q = q - 1;
      return q;
   endfunction

   function automatic coord_type to_screen(longint v, longint w, longint scale,
                                           longint offset);
      longint num, n;
      num = 2 * v - w;
      if (w == 0) n = (num > 0) ? S32_HI : ((num < 0) ? S32_LO : 0);
      else n = sat32((num * FRAC_ONE) / w);
      return coord_type'(sat32(floor_unit(scale * n) + offset));
   endfunction

   // Returns 1 when the segment survives clipping, with its screen endpoints.
   function automatic bit clip_and_project(seg_in_type s, output seg_out_type r);
      longint p0[4], p1[4], q0[4], q1[4], b0[6], b1[6];
      logic [5:0] c0, c1, crossed;
      longint a0, a1, a;
      p0 = '{longint'(s.start_x), longint'(s.start_y), longint'(s.start_z),
             longint'(s.start_w)};
      p1 = '{longint'(s.end_x), longint'(s.end_y), longint'(s.end_z),
             longint'(s.end_w)};
      r  = '0;
      for (int k = 0; k < 3; k++) begin
         b0[2*k] = p0[k]; b0[2*k+1] = p0[3] - p0[k];
         b1[2*k] = p1[k]; b1[2*k+1] = p1[3] - p1[k];
      end
      for (int k = 0; k < 6; k++) begin
         c0[k] = b0[k] < 0;
         c1[k] = b1[k] < 0;
      end
      if ((c0 & c1) != 0) return 0;
      crossed = c0 | c1;
      a0 = 0;
      a1 = FRAC_ONE;
      for (int k = 0; k < 6; k++) begin
         if (crossed[k]) begin
            a = (b0[k] * FRAC_ONE) / (b0[k] - b1[k]);
            if (c0[k]) begin
               if (a > a0) a0 = a;
            end else if (a < a1) a1 = a;
            if (a1 < a0) return 0;
         end
      end
      for (int k = 0; k < 4; k++) begin
         q0[k] = (c0 != 0) ? p0[k] + floor_unit(a0 * (p1[k] - p0[k])) : p0[k];
         q1[k] = (c1 != 0) ? p0[k] + floor_unit(a1 * (p1[k] - p0[k])) : p1[k];
      end
      r.screen_start_x = to_screen(q0[0], q0[3], vp_scale_x, vp_offset_x);
      r.screen_start_y = to_screen(q0[1], q0[3], vp_scale_y, vp_offset_y);
      r.screen_end_x   = to_screen(q1[0], q1[3], vp_scale_x, vp_offset_x);
      r.screen_end_y   = to_screen(q1[1], q1[3], vp_scale_y, vp_offset_y);
      r.was_clipped    = crossed != 0;
      return 1;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t: %s got %h, expected %h", $time, what, got, want);
      fails++;
   endtask

   always @(posedge clock) begin
      seg_out_type want, got;
      if (reset) begin
         vp_scale_x = 0; vp_offset_x = 0; vp_scale_y = 0; vp_offset_y = 0;
         screen_q.delete();
         fails = 0; n_seg = 0; n_drawn = 0; n_clipped = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_index_type'(csr_paddr[3:2]))
               REG_SCALE_X:  vp_scale_x  = longint'(signed'(csr_pwdata));
               REG_OFFSET_X: vp_offset_x = longint'(signed'(csr_pwdata));
               REG_SCALE_Y:  vp_scale_y  = longint'(signed'(csr_pwdata));
               REG_OFFSET_Y: vp_offset_y = longint'(signed'(csr_pwdata));
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (screen_q.size() == 0) begin
               report("unexpected transaction, start x", got.screen_start_x, 0);
            end else begin
               want = screen_q.pop_front();
               if (got.screen_start_x !== want.screen_start_x)
                  report("screen_start_x", got.screen_start_x, want.screen_start_x);
               if (got.screen_start_y !== want.screen_start_y)
                  report("screen_start_y", got.screen_start_y, want.screen_start_y);
               if (got.screen_end_x !== want.screen_end_x)
                  report("screen_end_x", got.screen_end_x, want.screen_end_x);
               if (got.screen_end_y !== want.screen_end_y)
                  report("screen_end_y", got.screen_end_y, want.screen_end_y);
               if (got.was_clipped !== want.was_clipped)
                  report("was_clipped", got.was_clipped, want.was_clipped);
            end
         end
         if (req_valid && req_ready) begin
            n_seg++;
            if (clip_and_project(req_data, want)) begin
               screen_q.push_back(want);
               n_drawn++;
               if (want.was_clipped) n_clipped++;
            end
         end
      end
      fail_count    <= fails;
      pending       <= screen_q.size();
      seg_count     <= n_seg;
      drawn_count   <= n_drawn;
      clipped_count <= n_clipped;
   end

endmodule

// File: tb/tb_top.sv
// Top of the clipper testbench: clock, reset, segment stimulus, receiver
// stalls, viewport writes and the verdict. Uses hlcp_pkg and hlcp_checker.
module tb_top
   import hlcp_pkg::*;
();

   localparam int     DRAIN_CYCLES = 80;
   localparam int     IDLE_LIMIT   = 4000;
   localparam int     RANDOM_SEGS  = 250;
   localparam int     ONE          = 32'sh10000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   seg_in_type            req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   seg_out_type           rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int fail_count, pending, seg_count, drawn_count, clipped_count;
   int burst_left = 0;
   int idle_cycles = 0;
   int stall_mode = 0;
   int stall_phase = 0;

   homogeneous_line_clip_project_core u_top (.*);

   hlcp_checker u_checker (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // The receiver switches at random between stall patterns.
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (stall_phase % 64 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= $urandom_range(0, 1);
         2: rsp_ready <= (stall_phase % 4) == 0;
         default: rsp_ready <= (stall_phase % 32) < 20;
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
         $display("FAIL homogeneous_line_clip_project_core");
         $finish;
      end
   end

   // Setup and access phase; the caller closes the last write of a series.
   task automatic csr_write(csr_index_type idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(idx) << 2;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
   endtask

   task automatic set_viewport(int sx, int ox, int sy, int oy);
      csr_write(REG_SCALE_X, sx);
      csr_write(REG_OFFSET_X, ox);
      csr_write(REG_SCALE_Y, sy);
      csr_write(REG_OFFSET_Y, oy);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_results;
      while (pending != 0) @(posedge clock);
   endtask

   task automatic drain;
      wait_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Sender works in bursts; a gap drops valid only between transactions.
   task automatic send_seg(seg_in_type s);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= s;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic stop_sending;
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
   endtask

   function automatic seg_in_type mk_seg(int x0, int y0, int z0, int w0,
                                         int x1, int y1, int z1, int w1);
      return '{x0, y0, z0, w0, x1, y1, z1, w1};
   endfunction

   // A coordinate a little around the span 0..w of its point.
   function automatic int near_span(int w);
      return int'($urandom_range(0, 2 * w)) - w / 2;
   endfunction

   function automatic seg_in_type random_seg;
      int w0, w1, shape, top;
      seg_in_type s;
      shape = $urandom_range(0, 9);
      if (shape == 0) begin
         s = {$urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom};
         return s;
      end
      top = (shape == 1) ? 255 : ((shape == 2) ? 32'h3FFF_FFFF : 32'h10_0000);
      w0 = $urandom_range(1, top);
      w1 = $urandom_range(1, top);
      if (shape == 3) w1 = -w1;
      return mk_seg(near_span(w0), near_span(w0), near_span(w0), w0,
                    near_span(w1), near_span(w1), near_span(w1), w1);
   endfunction

   task automatic send_directed;
      int h, q, t;
      h = ONE / 2; q = ONE / 4; t = 3 * ONE / 4;
      send_seg(mk_seg(q, q, h, ONE, t, h, h, ONE));
      send_seg(mk_seg(-h, q, h, ONE, -q, h, h, ONE));
      send_seg(mk_seg(-h, h, h, ONE, h, h, h, ONE));
      send_seg(mk_seg(h, h, h, ONE, ONE + h, h, h, ONE));
      send_seg(mk_seg(h, -h, h, ONE, h, h, h, ONE));
      send_seg(mk_seg(h, h, h, ONE, h, ONE + h, h, ONE));
      send_seg(mk_seg(h, h, -h, ONE, h, h, h, ONE));
      send_seg(mk_seg(h, h, h, ONE, h, h, ONE + h, ONE));
      send_seg(mk_seg(-h, h, h, ONE, ONE + h, h, h, ONE));
      send_seg(mk_seg(-h, -h, -h, ONE, ONE + h, ONE + h, ONE + h, ONE));
      // Enters through x after it has already left through y.
      send_seg(mk_seg(-h, h, h, ONE, h, 32'h1_9999, h, ONE));
      // Zero w: the point sits on every boundary and its NDC value is zero.
      send_seg(mk_seg(0, 0, 0, 0, 0, 0, 0, 0));
      send_seg(mk_seg(0, 0, 0, 0, h, h, h, ONE));
      // Tiny w of one unit, positive and negative.
      send_seg(mk_seg(1, 1, 0, 1, 0, 1, 1, 1));
      send_seg(mk_seg(0, 0, 0, -1, 0, 0, 0, -1));
      send_seg(mk_seg(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      0, 0, 0, 32'h7FFF_FFFF));
      send_seg(mk_seg(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      send_seg(mk_seg(32'h8000_0000, 0, 0, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF));
      send_seg('1);
   endtask

   task automatic send_random(int n);
      for (int i = 0; i < n; i++) begin
         send_seg(random_seg());
         // Halfway through, hold off until the pipeline has handed back everything.
         if (i == n / 2) begin
            stop_sending();
            wait_results();
         end
      end
      stop_sending();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_viewport(320 * ONE, 320 * ONE, -240 * ONE, 240 * ONE);
      send_directed();
      send_random(RANDOM_SEGS);
      drain();
      set_viewport(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
      send_directed();
      send_random(RANDOM_SEGS);
      drain();
      set_viewport(0, 0, 0, 0);
      send_random(RANDOM_SEGS / 2);
      drain();
      set_viewport($urandom, $urandom, $urandom, $urandom);
      send_random(RANDOM_SEGS);
      drain();
      $display("segments accepted: %0d, drawn: %0d, of those clipped: %0d",
               seg_count, drawn_count, clipped_count);
      $display("viewport covered default, screen-like, extreme and random settings");
      if (pending != 0) $display("%0d expected transactions never arrived", pending);
      if (fail_count == 0 && pending == 0) begin
         $display("PASS homogeneous_line_clip_project_core");
      end else begin
         $display("FAIL homogeneous_line_clip_project_core");
      end
      $finish;
   end

endmodule
